// ----- design/tdp_pkg.sv -----
`default_nettype none

package tdp_pkg;

  // trial divisors of the 6k +/- 1 scheme
  localparam int SMALL_PRIME_2  = 2;
  localparam int SMALL_PRIME_3  = 3;
  localparam int FIRST_DIVISOR  = 5;
  localparam int PAIR_GAP       = 2;
  localparam int DIVISOR_STRIDE = 6;

  // which divisor the shared divider is working on
  localparam logic [1:0] PH_THREE = 2'd0;
  localparam logic [1:0] PH_LOW   = 2'd1;
  localparam logic [1:0] PH_HIGH  = 2'd2;

endpackage

`default_nettype wire

// ----- design/tdp_div.sv -----
`default_nettype none

// restoring divider, one quotient bit per cycle
module tdp_div #(
  parameter int NW = 32,
  parameter int DW = 17
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] dividend,
  input  wire logic [DW-1:0] divisor,
  output logic               done,
  output logic [NW-1:0]      quotient,
  output logic [DW-1:0]      remainder
);

  localparam int CW = $clog2(NW + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [DW-1:0] sor_r, sor_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;

  assign trial = {rem_r, quo_r[NW-1]};
  assign diff  = trial - {1'b0, sor_r};
  assign fits  = trial >= {1'b0, sor_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sor_nxt  = sor_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(NW);
      sor_nxt  = divisor;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      // remainder stays below the divisor, so the low DW bits hold it
      rem_nxt = fits ? diff[DW-1:0] : trial[DW-1:0];
      quo_nxt = {quo_r[NW-2:0], fits};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    sor_r <= sor_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ----- design/trial_division_prime_test.sv -----
`default_nettype none

// trial-division primality test, 6k +/- 1 divisor pairs
//
// input channel: in_valid / in_stall carry one item, in_number, the value to
// test. an item is taken at a clock edge with in_valid high and in_stall low.
// in_stall is high from the edge that takes an item until the block is idle
// again; only one item is in work at a time.
// result channel: out_valid / out_stall carry one item per input, out_is_prime,
// held in an output register until the receiver takes it. a waiting result
// does not block the next input item; a finished second result waits in the
// done state until the output register frees up.
// path to out_valid: 0..3 and even numbers go straight to the done state;
// other multiples of 3 stop after the divide by 3. every other number
// costs one divide by 3, two divides per divisor pair and, when prime, a
// last divide that finds the bound, each on the single shared bit-serial
// divider; the pair count is about sqrt(n) / 6. a new item is taken only
// once the last one has left the done state, so any wait for the output
// register by a second result also holds off the next input.
// reset (synchronous, rst_n low) drops all valids and returns to idle.
// the divider's quotient also gives the loop bound: d <= n / d.
module trial_division_prime_test #(
  parameter int NUMBER_WIDTH = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_stall,
  input  wire logic [NUMBER_WIDTH-1:0] in_number,
  output logic                         out_valid,
  input  wire logic                    out_stall,
  output logic                         out_is_prime
);

  import tdp_pkg::*;

  localparam int NW = NUMBER_WIDTH;
  // divisor never passes sqrt(n) + stride, so half the width plus one bit
  localparam int DW = (NW + 1) / 2 + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [1:0]    phase_r, phase_nxt;
  logic [NW-1:0] num_r, num_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic          res_r, res_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_prime_r, out_prime_nxt;

  // divider control
  logic          start_r, start_nxt;
  logic [DW-1:0] sor_r, sor_nxt;
  logic          div_done;
  logic [NW-1:0] div_quo;
  logic [DW-1:0] div_rem;
  logic          rem_zero;
  logic          past_root;

  logic          in_take;
  logic          out_free;
  logic          small_two_three;
  logic          below_two;

  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign small_two_three = (in_number == NW'(SMALL_PRIME_2)) ||
                           (in_number == NW'(SMALL_PRIME_3));
  assign below_two       = in_number < NW'(SMALL_PRIME_2);

  assign rem_zero  = div_rem == '0;
  assign past_root = NW'(d_r) > div_quo;

  tdp_div #(
    .NW(NW),
    .DW(DW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start_r),
    .dividend (num_r),
    .divisor  (sor_r),
    .done     (div_done),
    .quotient (div_quo),
    .remainder(div_rem)
  );

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    num_nxt       = num_r;
    d_nxt         = d_r;
    res_nxt       = res_r;
    start_nxt     = 1'b0;
    sor_nxt       = sor_r;
    out_valid_nxt = out_valid_r;
    out_prime_nxt = out_prime_r;

    // result taken by the receiver
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          num_nxt = in_number;
          if (small_two_three) begin
            res_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else if (below_two || !in_number[0]) begin
            res_nxt   = 1'b0;
            state_nxt = S_DONE;
          end else begin
            // odd and at least 5: check by 3 first
            phase_nxt = PH_THREE;
            sor_nxt   = DW'(SMALL_PRIME_3);
            start_nxt = 1'b1;
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        if (div_done) begin
          case (phase_r)
            PH_THREE: begin
              if (rem_zero) begin
                res_nxt   = 1'b0;
                state_nxt = S_DONE;
              end else begin
                d_nxt     = DW'(FIRST_DIVISOR);
                sor_nxt   = DW'(FIRST_DIVISOR);
                phase_nxt = PH_LOW;
                start_nxt = 1'b1;
              end
            end
            PH_LOW: begin
              // loop bound first: d > n / d means no divisor left
              if (past_root) begin
                res_nxt   = 1'b1;
                state_nxt = S_DONE;
              end else if (rem_zero) begin
                res_nxt   = 1'b0;
                state_nxt = S_DONE;
              end else begin
                sor_nxt   = d_r + DW'(PAIR_GAP);
                phase_nxt = PH_HIGH;
                start_nxt = 1'b1;
              end
            end
            PH_HIGH: begin
              if (rem_zero) begin
                res_nxt   = 1'b0;
                state_nxt = S_DONE;
              end else begin
                d_nxt     = d_r + DW'(DIVISOR_STRIDE);
                sor_nxt   = d_r + DW'(DIVISOR_STRIDE);
                phase_nxt = PH_LOW;
                start_nxt = 1'b1;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_DONE: begin
        // hand the flag to the output register once it is free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_THREE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
    num_r       <= num_nxt;
    d_r         <= d_nxt;
    res_r       <= res_nxt;
    sor_r       <= sor_nxt;
    out_prime_r <= out_prime_nxt;
  end

  assign in_stall     = state_r != S_IDLE;
  assign out_valid    = out_valid_r;
  assign out_is_prime = out_prime_r;

endmodule

`default_nettype wire
